/* hdl/rrnp_pkg.sv */
// package for the reversed radix numeral parser
// shared widths, character constants, class codes and the queue item type
// no dependencies
package rrnp_pkg;

  localparam int DEF_VALUE_WIDTH = 32;
  localparam int CHAR_W          = 8;
  localparam int RADIX_W         = 5;
  localparam int DIG_W           = 5;
  localparam int QDEPTH          = 4;
  localparam int QPTR_W          = $clog2(QDEPTH);
  localparam int QCNT_W          = $clog2(QDEPTH + 1);

  localparam logic [RADIX_W-1:0] RADIX_RST = 5'd20;
  localparam logic [DIG_W-1:0]   LETTER_BASE = 5'd10;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_J  = 8'h4a;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_J  = 8'h6a;

  // character classes
  localparam logic [1:0] CLS_DIGIT   = 2'd0;
  localparam logic [1:0] CLS_NEWLINE = 2'd1;
  localparam logic [1:0] CLS_NUL     = 2'd2;
  localparam logic [1:0] CLS_BAD     = 2'd3;

  // result kinds
  localparam logic KIND_VALUE = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef struct packed {
    logic [1:0]        cls;
    logic [DIG_W-1:0]  digit;
    logic [CHAR_W-1:0] char_code;
  } item_t;

endpackage

/* hdl/rrnp_ifs.sv */
// channel interfaces of the reversed radix numeral parser
// character input, result output and radix configuration write
// depends on rrnp_pkg
interface rrnp_in_if;
  logic                         valid;
  logic                         ready;
  logic [rrnp_pkg::CHAR_W-1:0]  char_code;
  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface rrnp_out_if #(
  parameter int VALUE_WIDTH = rrnp_pkg::DEF_VALUE_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic                         result_kind;
  logic [VALUE_WIDTH-1:0]       value;
  logic [rrnp_pkg::CHAR_W-1:0]  bad_char;
  logic                         last;
  modport source (output valid, output result_kind, output value, output bad_char,
                  output last, input ready);
  modport sink   (input valid, input result_kind, input value, input bad_char,
                  input last, output ready);
endinterface

interface rrnp_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rrnp_pkg::RADIX_W-1:0] radix;
  modport source (output valid, output radix, input ready);
  modport sink   (input valid, input radix, output ready);
endinterface

/* hdl/rrnp_front.sv */
// front end: radix register, character handshake and classification
// pushes one classified item per accepted beat into the queue
// depends on rrnp_pkg and rrnp_ifs
module rrnp_front (
  input  logic                          clk,
  input  logic                          rst_n,
  rrnp_in_if.sink                       in_chan,
  rrnp_cfg_if.sink                      cfg_chan,
  input  logic                          q_ready,
  output logic                          q_push,
  output rrnp_pkg::item_t               q_item,
  output logic [rrnp_pkg::RADIX_W-1:0]  radix
);

  logic [rrnp_pkg::RADIX_W-1:0] radix_r;
  logic [rrnp_pkg::CHAR_W-1:0]  ch;
  logic [rrnp_pkg::CHAR_W-1:0]  dig_full;
  logic                         is_digit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= rrnp_pkg::RADIX_RST;
    end else if (cfg_chan.valid) begin
      radix_r <= cfg_chan.radix;
    end
  end

  assign cfg_chan.ready = 1'b1;
  assign radix          = radix_r;

  assign ch = in_chan.char_code;

  always_comb begin
    is_digit = 1'b1;
    if (ch >= rrnp_pkg::CH_ZERO && ch <= rrnp_pkg::CH_NINE) begin
      dig_full = ch - rrnp_pkg::CH_ZERO;
    end else if (ch >= rrnp_pkg::CH_LO_A && ch <= rrnp_pkg::CH_LO_J) begin
      dig_full = ch - rrnp_pkg::CH_LO_A + {3'b000, rrnp_pkg::LETTER_BASE};
    end else if (ch >= rrnp_pkg::CH_UP_A && ch <= rrnp_pkg::CH_UP_J) begin
      dig_full = ch - rrnp_pkg::CH_UP_A + {3'b000, rrnp_pkg::LETTER_BASE};
    end else begin
      dig_full = '0;
      is_digit = 1'b0;
    end
  end

  always_comb begin
    q_item.digit     = dig_full[rrnp_pkg::DIG_W-1:0];
    q_item.char_code = ch;
    // a digit at or above the radix is rejected like any other character
    if (is_digit && (dig_full[rrnp_pkg::DIG_W-1:0] < radix_r)) begin
      q_item.cls = rrnp_pkg::CLS_DIGIT;
    end else if (ch == rrnp_pkg::CH_LF) begin
      q_item.cls = rrnp_pkg::CLS_NEWLINE;
    end else if (ch == rrnp_pkg::CH_NUL) begin
      q_item.cls = rrnp_pkg::CLS_NUL;
    end else begin
      q_item.cls = rrnp_pkg::CLS_BAD;
    end
  end

  assign in_chan.ready = q_ready;
  assign q_push        = in_chan.valid && q_ready;

endmodule

/* hdl/rrnp_queue.sv */
// short queue of classified items between front and back
// register array with read and write pointers and a fill count
// depends on rrnp_pkg
module rrnp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rrnp_pkg::item_t  push_item,
  output logic             push_ready,
  input  logic             pop,
  output logic             head_valid,
  output rrnp_pkg::item_t  head_item
);

  rrnp_pkg::item_t               mem_r [rrnp_pkg::QDEPTH];
  logic [rrnp_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [rrnp_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [rrnp_pkg::QCNT_W-1:0]   count_r, count_nxt;
  logic                          do_pop;

  assign push_ready = (count_r != rrnp_pkg::QCNT_W'(rrnp_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* hdl/rrnp_back.sv */
// back end: accumulator and place value update, result output register
// nul takes two output beats, every other item at most one
// depends on rrnp_pkg and rrnp_ifs
module rrnp_back #(
  parameter int VALUE_WIDTH = rrnp_pkg::DEF_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [rrnp_pkg::RADIX_W-1:0]  radix,
  input  logic                          head_valid,
  input  rrnp_pkg::item_t               head_item,
  output logic                          pop,
  rrnp_out_if.source                    out_chan
);

  localparam int PROD_W = VALUE_WIDTH + rrnp_pkg::DIG_W;

  logic [VALUE_WIDTH-1:0]      acc_r, acc_nxt;
  logic [VALUE_WIDTH-1:0]      pv_r, pv_nxt;
  logic                        nul_r, nul_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        kind_r, kind_nxt;
  logic [VALUE_WIDTH-1:0]      value_r, value_nxt;
  logic [rrnp_pkg::CHAR_W-1:0] bad_r, bad_nxt;
  logic                        last_r, last_nxt;
  logic                        load;
  logic                        can_load;
  logic [PROD_W-1:0]           prod_d;
  logic [PROD_W-1:0]           prod_rdx;

  assign can_load = !out_valid_r || out_chan.ready;

  assign prod_d = {{rrnp_pkg::DIG_W{1'b0}}, pv_r} * {{VALUE_WIDTH{1'b0}}, head_item.digit};
  assign prod_rdx = {{rrnp_pkg::DIG_W{1'b0}}, pv_r} * {{VALUE_WIDTH{1'b0}}, radix};

  always_comb begin
    acc_nxt   = acc_r;
    pv_nxt    = pv_r;
    nul_nxt   = nul_r;
    pop       = 1'b0;
    load      = 1'b0;
    kind_nxt  = kind_r;
    value_nxt = value_r;
    bad_nxt   = bad_r;
    last_nxt  = last_r;
    if (head_valid) begin
      case (head_item.cls)
        rrnp_pkg::CLS_DIGIT: begin
          pop     = 1'b1;
          acc_nxt = acc_r + prod_d[VALUE_WIDTH-1:0];
          pv_nxt  = prod_rdx[VALUE_WIDTH-1:0];
        end
        rrnp_pkg::CLS_NEWLINE: begin
          if (can_load) begin
            pop       = 1'b1;
            load      = 1'b1;
            kind_nxt  = rrnp_pkg::KIND_VALUE;
            value_nxt = acc_r;
            bad_nxt   = '0;
            last_nxt  = 1'b1;
            acc_nxt   = '0;
            pv_nxt    = VALUE_WIDTH'(1);
          end
        end
        rrnp_pkg::CLS_NUL: begin
          if (can_load) begin
            load = 1'b1;
            if (!nul_r) begin
              // error beat first, item stays at the head
              kind_nxt  = rrnp_pkg::KIND_ERROR;
              value_nxt = '0;
              bad_nxt   = '0;
              last_nxt  = 1'b0;
              nul_nxt   = 1'b1;
            end else begin
              pop       = 1'b1;
              kind_nxt  = rrnp_pkg::KIND_VALUE;
              value_nxt = acc_r;
              bad_nxt   = '0;
              last_nxt  = 1'b1;
              nul_nxt   = 1'b0;
              acc_nxt   = '0;
              pv_nxt    = VALUE_WIDTH'(1);
            end
          end
        end
        rrnp_pkg::CLS_BAD: begin
          if (can_load) begin
            pop       = 1'b1;
            load      = 1'b1;
            kind_nxt  = rrnp_pkg::KIND_ERROR;
            value_nxt = '0;
            bad_nxt   = head_item.char_code;
            last_nxt  = 1'b1;
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
    out_valid_nxt = load || (out_valid_r && !out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      pv_r        <= VALUE_WIDTH'(1);
      nul_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      pv_r        <= pv_nxt;
      nul_r       <= nul_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
    bad_r   <= bad_nxt;
    last_r  <= last_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.result_kind = kind_r;
  assign out_chan.value       = value_r;
  assign out_chan.bad_char    = bad_r;
  assign out_chan.last        = last_r;

endmodule

/* hdl/reversed_radix_numeral_parser.sv */
// a character accepted at the input is written into the queue, and its result is then
// loaded into the result output register; throughput is one character per cycle while
// the queue is not full, and nul holds the back end for two output beats;
// the four-entry queue lets the input keep going while the output stalls
// reset (rst_n low, synchronous): radix 20, accumulator 0, place value 1,
// queue empty, no result pending
module reversed_radix_numeral_parser #(
  parameter int VALUE_WIDTH = rrnp_pkg::DEF_VALUE_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  rrnp_in_if.sink     in_chan,
  rrnp_cfg_if.sink    cfg_chan,
  rrnp_out_if.source  out_chan
);

  logic                          q_ready;
  logic                          q_push;
  rrnp_pkg::item_t               q_item;
  logic                          head_valid;
  rrnp_pkg::item_t               head_item;
  logic                          pop;
  logic [rrnp_pkg::RADIX_W-1:0]  radix;

  rrnp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_item   (q_item),
    .radix    (radix)
  );

  rrnp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .push_ready (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  rrnp_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .radix      (radix),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_chan   (out_chan)
  );

endmodule

/* hdl/rrnp_checker.sv */
// port-level checker for the reversed radix numeral parser
// bound to the top level; depends on rrnp_pkg
module rrnp_checker #(
  parameter int VALUE_WIDTH = rrnp_pkg::DEF_VALUE_WIDTH
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_kind,
  input logic [VALUE_WIDTH-1:0]       out_value,
  input logic [rrnp_pkg::CHAR_W-1:0]  out_bad,
  input logic                         out_last
);

  // a stalled beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_value)
      && $stable(out_bad) && $stable(out_last))
    else $error("result beat changed while stalled");

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // the nul error beat is followed at once by the value beat
  a_nul_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind == rrnp_pkg::KIND_ERROR && !out_last
      |=> out_valid && out_kind == rrnp_pkg::KIND_VALUE && out_last)
    else $error("nul error beat without its value beat");

  a_value_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == rrnp_pkg::KIND_VALUE |-> out_bad == '0 && out_last)
    else $error("value beat with bad char or without last");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == rrnp_pkg::KIND_ERROR |-> out_value == '0)
    else $error("error beat with nonzero value");

endmodule

bind reversed_radix_numeral_parser rrnp_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_rrnp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_kind  (out_chan.result_kind),
  .out_value (out_chan.value),
  .out_bad   (out_chan.bad_char),
  .out_last  (out_chan.last)
);
